[hdl/rwcm_pkg.sv]
// ---------------------------------------------------------------------------
// Range warp curve mapper package
// Shared constants, register indexes, curve codes and arithmetic helpers.
// ---------------------------------------------------------------------------
package rwcm_pkg;

    localparam int FRAC_BITS = 16;
    localparam int EXP_DEPTH = 64;
    localparam int QW        = FRAC_BITS + 1;

    localparam logic [QW-1:0] Q_ONE      = QW'(1) << FRAC_BITS;
    localparam logic [QW-1:0] SPAN_FLOOR = QW'(66);
    localparam logic [QW-1:0] EXP_FLOOR  = QW'(7);

    localparam longint unsigned Q30_ONE = 64'd1073741824;
    localparam longint unsigned K_Q30   = 64'd14268999427;
    localparam longint unsigned LN2_Q30 = 64'd744261118;

    localparam logic [2:0] REG_CURVE_MODE  = 3'd0;
    localparam logic [2:0] REG_IN_LOW      = 3'd1;
    localparam logic [2:0] REG_IN_HIGH     = 3'd2;
    localparam logic [2:0] REG_OUT_LOW     = 3'd3;
    localparam logic [2:0] REG_OUT_HIGH    = 3'd4;
    localparam logic [2:0] REG_QUANTIZE_ON = 3'd5;
    localparam logic [2:0] REG_STEP_COUNT  = 3'd6;

    localparam logic [3:0] MODE_LINEAR = 4'd0;
    localparam logic [3:0] MODE_EXP    = 4'd1;
    localparam logic [3:0] MODE_INVEXP = 4'd2;
    localparam logic [3:0] MODE_POW2   = 4'd3;
    localparam logic [3:0] MODE_POW3   = 4'd4;
    localparam logic [3:0] MODE_POW4   = 4'd5;
    localparam logic [3:0] MODE_POW5   = 4'd6;
    localparam logic [3:0] MODE_INV2   = 4'd7;
    localparam logic [3:0] MODE_INV3   = 4'd8;
    localparam logic [3:0] MODE_INV4   = 4'd9;
    localparam logic [3:0] MODE_INV5   = 4'd10;
    localparam logic [3:0] MODE_PH90   = 4'd11;
    localparam logic [3:0] MODE_PH180  = 4'd12;
    localparam logic [3:0] MODE_PH270  = 4'd13;

    typedef logic [EXP_DEPTH:0][QW-1:0] t_exp_rom;

    // Shift-and-subtract division, used only while the table is built.
    function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
        longint unsigned rem;
        longint unsigned quo;
        rem = 64'd0;
        quo = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            rem = (rem << 1) | ((num >> b) & 64'd1);
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | (64'd1 << b);
            end
        end
        return quo;
    endfunction

    function automatic longint unsigned exp2_neg_q30(longint unsigned k);
        longint unsigned ip;
        longint unsigned y;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        ip   = k >> 30;
        y    = ((k & (Q30_ONE - 64'd1)) * LN2_Q30) >> 30;
        term = Q30_ONE;
        pos  = Q30_ONE;
        neg  = 64'd0;
        for (int n = 1; n <= 12; n++) begin
            term = udiv((term * y) >> 30, 64'(n));
            if (n[0]) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        pos = pos - neg;
        return (ip >= 64'd31) ? 64'd0 : (pos >> ip);
    endfunction

    function automatic t_exp_rom exp_rom_build();
        t_exp_rom        rom;
        longint unsigned k;
        longint unsigned f;
        for (int i = 0; i <= EXP_DEPTH; i++) begin
            k      = udiv(K_Q30 * 64'(EXP_DEPTH - i), 64'(EXP_DEPTH));
            f      = exp2_neg_q30(k);
            rom[i] = QW'((f + (64'd1 << (30 - FRAC_BITS - 1))) >> (30 - FRAC_BITS));
        end
        return rom;
    endfunction

    localparam t_exp_rom EXP_ROM = exp_rom_build();

    function automatic logic [QW-1:0] sat_q(input logic [QW-1:0] v);
        return (v > Q_ONE) ? Q_ONE : v;
    endfunction

    function automatic logic [QW-1:0] mul_q(input logic [QW-1:0] a, input logic [QW-1:0] b);
        logic [2*QW-1:0] p;
        p = (2*QW)'(a) * (2*QW)'(b) + ((2*QW)'(1) << (FRAC_BITS - 1));
        return QW'(p >> FRAC_BITS);
    endfunction

endpackage

[hdl/range_warp_curve_mapper.sv]
// ---------------------------------------------------------------------------
// Range warp curve mapper
// Clamps and normalises a Q16 sample, optionally quantises it, applies a
// selectable curve and maps the result into the output range.
// ---------------------------------------------------------------------------
// Throughput is one item per cycle while the output is not stalled; the two
// 17-stage dividers set the depth.
// A stall at the output holds every stage in place.
// Reset clears all valid bits and loads the register defaults.
module range_warp_curve_mapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // [16:0] sample_in
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // [16:0] sample_out
    input  logic        i_cfg_wen,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    localparam int QW  = rwcm_pkg::QW;
    localparam int FB  = rwcm_pkg::FRAC_BITS;
    localparam int ABW = $clog2(rwcm_pkg::EXP_DEPTH);
    localparam int IW  = ABW + 1;

    logic [3:0]    r_curve_mode;
    logic [QW-1:0] r_in_low;
    logic [QW-1:0] r_in_high;
    logic [QW-1:0] r_out_low;
    logic [QW-1:0] r_out_high;
    logic          r_quantize_on;
    logic [7:0]    r_step_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_mode  <= rwcm_pkg::MODE_LINEAR;
            r_in_low      <= '0;
            r_in_high     <= rwcm_pkg::Q_ONE;
            r_out_low     <= '0;
            r_out_high    <= rwcm_pkg::Q_ONE;
            r_quantize_on <= 1'b0;
            r_step_count  <= 8'd2;
        end else if (i_cfg_wen) begin
            case (i_cfg_index)
                rwcm_pkg::REG_CURVE_MODE:  r_curve_mode  <= i_cfg_data[3:0];
                rwcm_pkg::REG_IN_LOW:      r_in_low      <= i_cfg_data;
                rwcm_pkg::REG_IN_HIGH:     r_in_high     <= i_cfg_data;
                rwcm_pkg::REG_OUT_LOW:     r_out_low     <= i_cfg_data;
                rwcm_pkg::REG_OUT_HIGH:    r_out_high    <= i_cfg_data;
                rwcm_pkg::REG_QUANTIZE_ON: r_quantize_on <= i_cfg_data[0];
                rwcm_pkg::REG_STEP_COUNT:  r_step_count  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    logic          w_en;
    logic          r_out_vld;
    logic [QW-1:0] r_out_data;

    assign w_en            = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // Input range, clamp and span.
    logic          w_exp_mode;
    logic [QW-1:0] w_x, w_lo, w_hi, w_lim, w_span, w_diff;

    always_comb begin
        w_exp_mode = (r_curve_mode == rwcm_pkg::MODE_EXP) ||
                     (r_curve_mode == rwcm_pkg::MODE_INVEXP);
        w_x  = i_s_axis_tdata[QW-1:0];
        w_lo = rwcm_pkg::sat_q(r_in_low);
        w_hi = rwcm_pkg::sat_q(r_in_high);
        if (w_exp_mode && w_lo < rwcm_pkg::EXP_FLOOR) begin
            w_lo = rwcm_pkg::EXP_FLOOR;
        end
        if (w_exp_mode && w_hi < rwcm_pkg::EXP_FLOOR) begin
            w_hi = rwcm_pkg::EXP_FLOOR;
        end
        w_lim = (w_x < w_lo) ? w_lo : w_x;
        if (w_lim > w_hi) begin
            w_lim = w_hi;
        end
        w_span = (w_hi > w_lo) ? w_hi - w_lo : '0;
        if (w_span < rwcm_pkg::SPAN_FLOOR) begin
            w_span = rwcm_pkg::SPAN_FLOOR;
        end
        w_diff = (w_lim >= w_lo) ? w_lim - w_lo : '0;
    end

    logic          w_v1;
    logic [QW-1:0] w_q1;
    logic          w_t1;

    rwcm_div #(.NW(QW + FB), .DW(QW), .QW(QW), .TW(1)) u_norm_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_num   ({w_diff, FB'(0)}),
        .i_den   (w_span),
        .i_tag   (1'b0),
        .o_valid (w_v1),
        .o_quo   (w_q1),
        .o_tag   (w_t1)
    );

    // Step quantisation: level index.
    logic [7:0]    w_n;
    logic [6:0]    w_nm1;
    logic [QW+7:0] w_sn;
    logic [8:0]    w_qq;
    logic          r1_vld;
    logic [QW-1:0] r1_s;
    logic [6:0]    r1_q;

    always_comb begin
        w_n = r_step_count;
        if (w_n < 8'd2) begin
            w_n = 8'd2;
        end else if (w_n > 8'd128) begin
            w_n = 8'd128;
        end
        w_nm1 = 7'(w_n - 8'd1);
        w_sn  = (QW+8)'(w_q1) * (QW+8)'(w_n);
        w_qq  = w_sn[FB+8:FB];
        if (w_qq > {2'b00, w_nm1}) begin
            w_qq = {2'b00, w_nm1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= w_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_s <= w_q1;
            r1_q <= w_qq[6:0];
        end
    end

    logic          w_v2;
    logic [QW-1:0] w_q2;
    logic [QW-1:0] w_s2;

    rwcm_div #(.NW(7 + FB), .DW(7), .QW(QW), .TW(QW)) u_quant_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r1_vld),
        .i_num   ({r1_q, FB'(0)} + (7 + FB)'(w_nm1 >> 1)),
        .i_den   (w_nm1),
        .i_tag   (r1_s),
        .o_valid (w_v2),
        .o_quo   (w_q2),
        .o_tag   (w_s2)
    );

    // Curve stage 1: curve argument and table read.
    logic          w_inv_arg;
    logic [QW-1:0] w_sq, w_arg;
    logic [IW-1:0] w_ia, w_ib;
    logic [QW-1:0] w_ra, w_rb;

    always_comb begin
        w_inv_arg = (r_curve_mode == rwcm_pkg::MODE_INVEXP) ||
                    (r_curve_mode >= rwcm_pkg::MODE_INV2 &&
                     r_curve_mode <= rwcm_pkg::MODE_INV5);
        w_sq  = r_quantize_on ? w_q2 : w_s2;
        w_arg = w_inv_arg ? rwcm_pkg::Q_ONE - w_sq : w_sq;
        w_ia  = w_arg[FB:FB-ABW];
        w_ib  = (w_ia == IW'(rwcm_pkg::EXP_DEPTH)) ? w_ia : w_ia + IW'(1);
        w_ra  = rwcm_pkg::EXP_ROM[w_ia];
        w_rb  = rwcm_pkg::EXP_ROM[w_ib];
    end

    logic [5:0]          r_vld;
    logic [QW-1:0]       r2_x, r2_s, r2_a, r2_d;
    logic                r2_up;
    logic [FB-ABW-1:0]   r2_fr;
    logic [QW-1:0]       r3_x, r3_s, r3_a, r3_p2;
    logic                r3_up;
    logic [QW+FB-ABW-1:0] r3_pe;
    logic [QW-1:0]       r4_x, r4_s, r4_e, r4_p2, r4_p3;
    logic [QW-1:0]       r5_x, r5_s, r5_e, r5_p2, r5_p3, r5_p4;
    logic [QW-1:0]       r6_s, r6_e, r6_p2, r6_p3, r6_p4, r6_p5;
    logic [2*QW-1:0]     r7_p;
    logic                r7_up;

    logic [QW-1:0] w_c, w_pw, w_dm;
    logic          w_oup;

    always_comb begin
        case (r_curve_mode)
            rwcm_pkg::MODE_POW2, rwcm_pkg::MODE_INV2: w_pw = r6_p2;
            rwcm_pkg::MODE_POW3, rwcm_pkg::MODE_INV3: w_pw = r6_p3;
            rwcm_pkg::MODE_POW4, rwcm_pkg::MODE_INV4: w_pw = r6_p4;
            default:                                  w_pw = r6_p5;
        endcase
        case (r_curve_mode) inside
            rwcm_pkg::MODE_EXP:    w_c = r6_e;
            rwcm_pkg::MODE_INVEXP: w_c = rwcm_pkg::Q_ONE - r6_e;
            [rwcm_pkg::MODE_POW2:rwcm_pkg::MODE_POW5]: w_c = w_pw;
            [rwcm_pkg::MODE_INV2:rwcm_pkg::MODE_INV5]: w_c = rwcm_pkg::Q_ONE - w_pw;
            rwcm_pkg::MODE_PH90:   w_c = {1'b0, r6_s[FB-1:0] + (FB'(1) << (FB - 2))};
            rwcm_pkg::MODE_PH180:  w_c = {1'b0, r6_s[FB-1:0] + (FB'(1) << (FB - 1))};
            rwcm_pkg::MODE_PH270:  w_c = {1'b0, r6_s[FB-1:0] + (FB'(3) << (FB - 2))};
            default:               w_c = r6_s;
        endcase
        w_c   = rwcm_pkg::sat_q(w_c);
        w_oup = rwcm_pkg::sat_q(r_out_high) >= rwcm_pkg::sat_q(r_out_low);
        w_dm  = w_oup ? rwcm_pkg::sat_q(r_out_high) - rwcm_pkg::sat_q(r_out_low)
                      : rwcm_pkg::sat_q(r_out_low) - rwcm_pkg::sat_q(r_out_high);
    end

    logic [QW-1:0] w_rnd, w_res, w_olo;

    always_comb begin
        w_olo = rwcm_pkg::sat_q(r_out_low);
        w_rnd = QW'((r7_p + ((2*QW)'(1) << (FB - 1))) >> FB);
        w_res = r7_up ? w_olo + w_rnd : w_olo - w_rnd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld     <= {r_vld[4:0], w_v2};
            r_out_vld <= r_vld[5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_x  <= w_arg;
            r2_s  <= w_sq;
            r2_a  <= w_ra;
            r2_up <= (w_rb >= w_ra);
            r2_d  <= (w_rb >= w_ra) ? w_rb - w_ra : w_ra - w_rb;
            r2_fr <= w_arg[FB-ABW-1:0];

            r3_x  <= r2_x;
            r3_s  <= r2_s;
            r3_a  <= r2_a;
            r3_up <= r2_up;
            r3_pe <= (QW+FB-ABW)'(r2_d) * (QW+FB-ABW)'(r2_fr);
            r3_p2 <= rwcm_pkg::mul_q(r2_x, r2_x);

            r4_x  <= r3_x;
            r4_s  <= r3_s;
            r4_e  <= r3_up ? r3_a + QW'(r3_pe >> (FB - ABW))
                           : r3_a - QW'(r3_pe >> (FB - ABW));
            r4_p2 <= r3_p2;
            r4_p3 <= rwcm_pkg::mul_q(r3_p2, r3_x);

            r5_x  <= r4_x;
            r5_s  <= r4_s;
            r5_e  <= r4_e;
            r5_p2 <= r4_p2;
            r5_p3 <= r4_p3;
            r5_p4 <= rwcm_pkg::mul_q(r4_p3, r4_x);

            r6_s  <= r5_s;
            r6_e  <= r5_e;
            r6_p2 <= r5_p2;
            r6_p3 <= r5_p3;
            r6_p4 <= r5_p4;
            r6_p5 <= rwcm_pkg::mul_q(r5_p4, r5_x);

            r7_p  <= (2*QW)'(w_dm) * (2*QW)'(w_c);
            r7_up <= w_oup;

            r_out_data <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {(24 - QW)'(0), r_out_data};

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata <= 24'(rwcm_pkg::Q_ONE)))
        else $error("result beyond 1.0");

    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_v1 |-> (w_q1 <= rwcm_pkg::Q_ONE))
        else $error("normalised value beyond 1.0");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r1_vld |-> (r1_q <= w_nm1))
        else $error("quantisation level beyond last step");

    a_quant_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_v2 |-> (w_q2 <= rwcm_pkg::Q_ONE))
        else $error("quantised value beyond 1.0");

endmodule

[hdl/rwcm_div.sv]
// ---------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; a tag and a valid bit travel with each item.
// ---------------------------------------------------------------------------
module rwcm_div #(
    parameter int NW = 33,
    parameter int DW = 17,
    parameter int QW = 17,
    parameter int TW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [TW-1:0] o_tag
);

    logic [QW-1:0] r_vld;
    logic [QW-1:0] n_vld;
    logic [DW-1:0] r_rem [QW];
    logic [DW-1:0] n_rem [QW];
    logic [QW-1:0] r_low [QW];
    logic [QW-1:0] n_low [QW];
    logic [QW-1:0] r_quo [QW];
    logic [QW-1:0] n_quo [QW];
    logic [DW-1:0] r_den [QW];
    logic [DW-1:0] n_den [QW];
    logic [TW-1:0] r_tag [QW];
    logic [TW-1:0] n_tag [QW];

    always_comb begin
        logic [DW-1:0] v_rem;
        logic [DW-1:0] v_den;
        logic [QW-1:0] v_low;
        logic [QW-1:0] v_quo;
        logic [TW-1:0] v_tag;
        logic          v_vld;
        logic [DW:0]   v_trial;
        logic          v_bit;
        for (int k = 0; k < QW; k++) begin
            if (k == 0) begin
                v_rem = DW'(i_num[NW-1:QW]);
                v_low = i_num[QW-1:0];
                v_quo = '0;
                v_den = i_den;
                v_tag = i_tag;
                v_vld = i_valid;
            end else begin
                v_rem = r_rem[k-1];
                v_low = r_low[k-1];
                v_quo = r_quo[k-1];
                v_den = r_den[k-1];
                v_tag = r_tag[k-1];
                v_vld = r_vld[k-1];
            end
            v_trial = {v_rem, v_low[QW-1]};
            v_bit   = (v_trial >= {1'b0, v_den});
            n_rem[k] = v_bit ? DW'(v_trial - {1'b0, v_den}) : v_trial[DW-1:0];
            n_low[k] = v_low << 1;
            n_quo[k] = {v_quo[QW-2:0], v_bit};
            n_den[k] = v_den;
            n_tag[k] = v_tag;
            n_vld[k] = v_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_low <= n_low;
            r_quo <= n_quo;
            r_den <= n_den;
            r_tag <= n_tag;
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_tag   = r_tag[QW-1];

endmodule

[dv/range_warp_curve_mapper_tb.sv]
// ---------------------------------------------------------------------------
// Range warp curve mapper testbench
// Drives Q16 samples through the mapper under a series of register settings,
// predicts each result with an independent model of the clamp, normalise,
// quantise, curve and output mapping steps, and compares in order.
// ---------------------------------------------------------------------------
module range_warp_curve_mapper_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 41;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [23:0] o_m_axis_tdata;
    logic        i_cfg_wen;
    logic [2:0]  i_cfg_index;
    logic [16:0] i_cfg_data;

    range_warp_curve_mapper u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // [16:0] sample_in
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [16:0] sample_out
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Shadow registers
    logic [3:0]  mode_r;
    logic [16:0] in_lo_r, in_hi_r, out_lo_r, out_hi_r;
    logic        quant_r;
    logic [7:0]  steps_r;
    longint unsigned warp_rom [0:rwcm_pkg::EXP_DEPTH];

    logic [16:0] sample_q [$];
    logic [16:0] mapped_q [$];
    int          mismatches;
    bit          hold_sink;
    int          sink_hold_cycles;

    function automatic longint unsigned pow2_neg(longint unsigned k);
        longint unsigned whole, y, t, acc_p, acc_n;
        whole = k >> 30;
        y     = ((k & 64'h3FFF_FFFF) * rwcm_pkg::LN2_Q30) >> 30;
        t     = rwcm_pkg::Q30_ONE;
        acc_p = rwcm_pkg::Q30_ONE;
        acc_n = 0;
        for (int n = 1; n <= 12; n++) begin
            t = ((t * y) >> 30) / n;
            if (n & 1) acc_n += t;
            else acc_p += t;
        end
        acc_p -= acc_n;
        return (whole >= 31) ? 0 : (acc_p >> whole);
    endfunction

    function automatic longint unsigned warp_lookup(longint unsigned s);
        longint unsigned p, idx, fr, a, b;
        p   = s * rwcm_pkg::EXP_DEPTH;
        idx = p >> 16;
        fr  = p & 16'hFFFF;
        if (idx >= rwcm_pkg::EXP_DEPTH) return warp_rom[rwcm_pkg::EXP_DEPTH];
        a = warp_rom[idx];
        b = warp_rom[idx + 1];
        if (b >= a) return a + (((b - a) * fr) >> 16);
        return a - (((a - b) * fr) >> 16);
    endfunction

    function automatic longint unsigned raise(longint unsigned s, int n);
        longint unsigned p;
        p = s;
        for (int i = 1; i < n; i++) p = (p * s + 32768) >> 16;
        return p;
    endfunction

    function automatic longint unsigned clip1(longint unsigned v);
        return (v > 65536) ? 65536 : v;
    endfunction

    function automatic logic [16:0] map_sample(logic [16:0] x_in);
        longint unsigned x, lo, hi, olo, ohi, lim, span, s, c, r, n, q;
        x   = x_in;
        lo  = clip1(in_lo_r);
        hi  = clip1(in_hi_r);
        olo = clip1(out_lo_r);
        ohi = clip1(out_hi_r);
        if (mode_r == rwcm_pkg::MODE_EXP || mode_r == rwcm_pkg::MODE_INVEXP) begin
            if (lo < 7) lo = 7;
            if (hi < 7) hi = 7;
        end
        lim = (x < lo) ? lo : x;
        if (lim > hi) lim = hi;
        span = (hi > lo) ? hi - lo : 0;
        if (span < 66) span = 66;
        s = (lim >= lo) ? ((lim - lo) << 16) / span : 0;
        if (s > 65536) s = 65536;
        if (quant_r) begin
            n = steps_r;
            if (n < 2) n = 2;
            if (n > 128) n = 128;
            q = (s * n) >> 16;
            if (q > n - 1) q = n - 1;
            s = (q * 65536 + (n - 1) / 2) / (n - 1);
        end
        case (mode_r)
            rwcm_pkg::MODE_EXP:    c = warp_lookup(s);
            rwcm_pkg::MODE_INVEXP: c = 65536 - warp_lookup(65536 - s);
            rwcm_pkg::MODE_POW2, rwcm_pkg::MODE_POW3,
            rwcm_pkg::MODE_POW4, rwcm_pkg::MODE_POW5:
                c = raise(s, mode_r - 1);
            rwcm_pkg::MODE_INV2, rwcm_pkg::MODE_INV3,
            rwcm_pkg::MODE_INV4, rwcm_pkg::MODE_INV5:
                c = 65536 - raise(65536 - s, mode_r - 5);
            rwcm_pkg::MODE_PH90:   c = (s + 16384) & 16'hFFFF;
            rwcm_pkg::MODE_PH180:  c = (s + 32768) & 16'hFFFF;
            rwcm_pkg::MODE_PH270:  c = (s + 49152) & 16'hFFFF;
            default:               c = s;
        endcase
        if (c > 65536) c = 65536;
        if (ohi >= olo) r = olo + (((ohi - olo) * c + 32768) >> 16);
        else r = olo - (((olo - ohi) * c + 32768) >> 16);
        return r[16:0];
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [16:0] val);
        @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            rwcm_pkg::REG_CURVE_MODE:  mode_r   = val[3:0];
            rwcm_pkg::REG_IN_LOW:      in_lo_r  = val;
            rwcm_pkg::REG_IN_HIGH:     in_hi_r  = val;
            rwcm_pkg::REG_OUT_LOW:     out_lo_r = val;
            rwcm_pkg::REG_OUT_HIGH:    out_hi_r = val;
            rwcm_pkg::REG_QUANTIZE_ON: quant_r  = val[0];
            rwcm_pkg::REG_STEP_COUNT:  steps_r  = val[7:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
    endtask

    task automatic drain();
        while (sample_q.size() != 0 || mapped_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    function automatic logic [16:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'($urandom_range(65537, 131071));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [16:0] rand_bound();
        case ($urandom_range(0, 9))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'($urandom_range(65537, 131071));
            3: return 17'($urandom_range(0, 100));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    // Driver
    int src_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            src_gap         <= 0;
        end else if (i_s_axis_tvalid && !o_s_axis_tready) begin
        end else if (src_gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            src_gap         <= src_gap - 1;
        end else if (sample_q.size() != 0) begin
            i_s_axis_tvalid <= 1'b1;
            i_s_axis_tdata  <= {7'd0, sample_q[0]};
            mapped_q.push_back(map_sample(sample_q[0]));
            void'(sample_q.pop_front());
            src_gap <= $urandom_range(0, 3);
        end else begin
            i_s_axis_tvalid <= 1'b0;
        end
    end

    // Monitor and sink stall
    int sink_gap;
    always @(posedge i_clk) begin
        int v_gap;
        v_gap = sink_gap;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            sink_gap        <= 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (mapped_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item: actual %0d", o_m_axis_tdata[16:0]);
                end else begin
                    if (o_m_axis_tdata[16:0] !== mapped_q[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: mode %0d expected %0d actual %0d",
                                     mode_r, mapped_q[0], o_m_axis_tdata[16:0]);
                    end
                    void'(mapped_q.pop_front());
                end
                v_gap = $urandom_range(0, 3);
            end
            if (sink_hold_cycles > 0) begin
                i_m_axis_tready  <= 1'b0;
                sink_hold_cycles <= sink_hold_cycles - 1;
            end else if (hold_sink) begin
                i_m_axis_tready  <= 1'b0;
                sink_hold_cycles <= 200;
                hold_sink        <= 1'b0;
            end else if (v_gap > 0) begin
                i_m_axis_tready <= 1'b0;
                v_gap           = v_gap - 1;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
            sink_gap <= v_gap;
        end
    end

    initial begin
        #40ms;
        $display("tb: failure");
        $finish;
    end

    initial begin
        logic [3:0] m;
        i_rst_n          = 1'b0;
        i_cfg_wen        = 1'b0;
        i_cfg_index      = rwcm_pkg::REG_CURVE_MODE;
        i_cfg_data       = '0;
        i_s_axis_tvalid  = 1'b0;
        i_s_axis_tdata   = '0;
        i_m_axis_tready  = 1'b0;
        mismatches       = 0;
        hold_sink        = 1'b0;
        sink_hold_cycles = 0;
        mode_r   = rwcm_pkg::MODE_LINEAR;
        in_lo_r  = 17'd0;
        in_hi_r  = 17'd65536;
        out_lo_r = 17'd0;
        out_hi_r = 17'd65536;
        quant_r  = 1'b0;
        steps_r  = 8'd2;
        for (int i = 0; i <= rwcm_pkg::EXP_DEPTH; i++)
            warp_rom[i] = (pow2_neg((rwcm_pkg::K_Q30 * (rwcm_pkg::EXP_DEPTH - i))
                                    / rwcm_pkg::EXP_DEPTH) + 8192) >> 14;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every curve with extreme and out-of-range samples.
        for (int k = 0; k < 16; k++) begin
            write_reg(rwcm_pkg::REG_CURVE_MODE, 17'(k));
            sample_q.push_back(17'd0);
            sample_q.push_back(17'd65536);
            sample_q.push_back(17'd131071);
            sample_q.push_back(17'd32768);
            drain();
        end
        // Inverted ranges, tiny span, descending output, quantise extremes.
        write_reg(rwcm_pkg::REG_CURVE_MODE, {13'd0, rwcm_pkg::MODE_EXP});
        write_reg(rwcm_pkg::REG_IN_LOW, 17'd40000);
        write_reg(rwcm_pkg::REG_IN_HIGH, 17'd3);
        write_reg(rwcm_pkg::REG_OUT_LOW, 17'd131071);
        write_reg(rwcm_pkg::REG_OUT_HIGH, 17'd0);
        write_reg(rwcm_pkg::REG_QUANTIZE_ON, 17'd1);
        write_reg(rwcm_pkg::REG_STEP_COUNT, 17'd255);
        sample_q.push_back(17'd0);
        sample_q.push_back(17'd50000);
        sample_q.push_back(17'd65536);
        drain();
        write_reg(rwcm_pkg::REG_STEP_COUNT, 17'd0);
        write_reg(rwcm_pkg::REG_IN_LOW, 17'd1000);
        write_reg(rwcm_pkg::REG_IN_HIGH, 17'd1010);
        write_reg(3'd7, 17'd5);
        sample_q.push_back(17'd1005);
        sample_q.push_back(17'd131071);
        drain();

        // Random phases.
        for (int ph = 0; ph < 28; ph++) begin
            m = 4'($urandom_range(0, 15));
            write_reg(rwcm_pkg::REG_CURVE_MODE, {13'd0, m});
            write_reg(rwcm_pkg::REG_IN_LOW, (ph % 3 == 0) ? 17'd0 : rand_bound());
            write_reg(rwcm_pkg::REG_IN_HIGH, (ph % 3 == 0) ? 17'd65536 : rand_bound());
            write_reg(rwcm_pkg::REG_OUT_LOW, rand_bound());
            write_reg(rwcm_pkg::REG_OUT_HIGH, rand_bound());
            write_reg(rwcm_pkg::REG_QUANTIZE_ON, 17'($urandom_range(0, 1)));
            write_reg(rwcm_pkg::REG_STEP_COUNT, 17'($urandom_range(0, 255)));
            if (ph == 5) hold_sink = 1'b1;
            for (int i = 0; i < 50; i++) sample_q.push_back(rand_sample());
            drain();
        end

        drain();
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[files.f]
hdl/rwcm_pkg.sv
hdl/rwcm_div.sv
hdl/range_warp_curve_mapper.sv
dv/range_warp_curve_mapper_tb.sv
